[sv/svx_pkg.sv]
// shared types and constants for the shadow volume extruder
// no dependencies; imported by the top level, the front, the queue and the back
`timescale 1ns / 1ps

package svx_pkg;

  // one coordinate triple, element 0 is x, 1 is y, 2 is z
  typedef logic [2:0][31:0] vec_t;

  // light * extrude_length per axis, signed 48 bits
  typedef logic [2:0][47:0] lprod_t;

  // one facing triangle handed from the front to the back
  typedef struct packed {
    vec_t [2:0] v;
    lprod_t     lp;
  } tri_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // configuration register indexes
  localparam logic [1:0] CfgLightX = 2'd0;
  localparam logic [1:0] CfgLightY = 2'd1;
  localparam logic [1:0] CfgLightZ = 2'd2;
  localparam logic [1:0] CfgExtLen = 2'd3;

  // configuration reset values
  localparam logic [31:0] LightXRst = 32'h0000_0000;
  localparam logic [31:0] LightYRst = 32'hFFFF_0000;
  localparam logic [31:0] LightZRst = 32'h0000_0000;
  localparam logic [15:0] ExtLenRst = 16'd100;

endpackage

[sv/shadow_volume_triangle_extruder.sv]
// the front works on one triangle at a time and computes 15 products on one shared
// multiplier; it takes no new triangle until it is through, and a facing triangle
// then leaves as 18 beats, one per cycle while the output is not stalled
// reset: asynchronous, active low; clears control state and loads the light
// and extrude length defaults
`timescale 1ns / 1ps

module shadow_volume_triangle_extruder #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  input  logic [31:0] c_x_i,
  input  logic [31:0] c_y_i,
  input  logic [31:0] c_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        last_vertex_o
);
  import svx_pkg::*;

  vec_t       light_q;
  logic [15:0] ext_len_q;
  vec_t [2:0] vtx_in;
  q_stat_t    q_stat;
  tri_t       push_data, pop_data;
  logic       push, pop;
  vec_t       out_vtx;

  assign vtx_in[0] = {a_z_i, a_y_i, a_x_i};
  assign vtx_in[1] = {b_z_i, b_y_i, b_x_i};
  assign vtx_in[2] = {c_z_i, c_y_i, c_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q[0] <= LightXRst;
      light_q[1] <= LightYRst;
      light_q[2] <= LightZRst;
      ext_len_q  <= ExtLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLightX: light_q[0] <= cfg_wdata_i;
        CfgLightY: light_q[1] <= cfg_wdata_i;
        CfgLightZ: light_q[2] <= cfg_wdata_i;
        CfgExtLen: ext_len_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  svx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vtx_i       (vtx_in),
    .light_i     (light_q),
    .ext_len_i   (ext_len_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  svx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  svx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_vtx_o   (out_vtx),
    .out_last_o  (last_vertex_o)
  );

  assign out_x_o = out_vtx[0];
  assign out_y_o = out_vtx[1];
  assign out_z_o = out_vtx[2];

endmodule

[sv/svx_front.sv]
// front end: takes a triangle, runs the facing test and the extrusion products
// on one shared 35x33 multiplier; depends on svx_pkg
`timescale 1ns / 1ps

module svx_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  svx_pkg::vec_t [2:0] vtx_i,
  input  svx_pkg::vec_t    light_i,
  input  logic [15:0]      ext_len_i,
  input  svx_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output svx_pkg::tri_t    push_data_o
);
  import svx_pkg::*;

  // multiplier schedule: 6 normal products, 6 dot halves, 3 light products
  localparam logic [4:0] StepDot    = 5'd6;
  localparam logic [4:0] StepExt    = 5'd12;
  localparam logic [4:0] StepAccEnd = 5'd15;
  localparam logic [4:0] StepLast   = 5'd16;

  logic               busy_q;
  logic [4:0]         step_q;
  vec_t [2:0]         vtx_q;
  logic signed [32:0] d1_q [3];
  logic signed [32:0] d2_q [3];
  logic signed [66:0] n_q [3];
  logic signed [101:0] dot_q;
  logic [47:0]        lp_q [3];
  logic signed [67:0] prod_q;
  logic signed [34:0] opa;
  logic signed [32:0] opb;
  logic [4:0]         rel_dot, rel_ext, pstep, prel_dot, prel_ext;
  logic [31:0]        lsel;
  logic [66:0]        nsel;
  logic [101:0]       prod_ext;
  logic               facing, finish, accept;

  function automatic logic signed [34:0] sx35(input logic [32:0] a);
    return {{2{a[32]}}, a};
  endfunction

  function automatic logic signed [32:0] sx33(input logic [31:0] a);
    return {a[31], a};
  endfunction

  assign facing     = ~dot_q[101];
  assign finish     = busy_q && (step_q == StepLast) && (!facing || !q_stat_i.full);
  assign push_o     = finish && facing;
  assign in_stall_o = busy_q && !finish;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    push_data_o.v = vtx_q;
    for (int j = 0; j < 3; j++) begin
      push_data_o.lp[j] = lp_q[j];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    rel_dot = step_q - StepDot;
    rel_ext = step_q - StepExt;
    lsel    = '0;
    nsel    = '0;
    opa     = '0;
    opb     = '0;
    if (step_q < StepDot) begin
      case (step_q[2:0])
        3'd0: begin opa = sx35(d1_q[1]); opb = d2_q[2]; end
        3'd1: begin opa = sx35(d1_q[2]); opb = d2_q[1]; end
        3'd2: begin opa = sx35(d1_q[2]); opb = d2_q[0]; end
        3'd3: begin opa = sx35(d1_q[0]); opb = d2_q[2]; end
        3'd4: begin opa = sx35(d1_q[0]); opb = d2_q[1]; end
        3'd5: begin opa = sx35(d1_q[1]); opb = d2_q[0]; end
        default: begin opa = '0; opb = '0; end
      endcase
    end else if (step_q < StepExt) begin
      // n split into a signed upper 33 bits and an unsigned lower 34 bits
      lsel = light_i[rel_dot[2:1]];
      nsel = n_q[rel_dot[2:1]];
      opb  = 33'sd0 - sx33(lsel);
      if (!rel_dot[0]) begin
        opa = sx35(nsel[66:34]);
      end else begin
        opa = {1'b0, nsel[33:0]};
      end
    end else if (step_q < StepAccEnd) begin
      lsel = light_i[rel_ext[1:0]];
      opa  = {{3{lsel[31]}}, lsel};
      opb  = {17'd0, ext_len_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
  end

  // accumulation works on the registered product of the previous step
  always_comb begin
    pstep    = step_q - 5'd1;
    prel_dot = pstep - StepDot;
    prel_ext = pstep - StepExt;
    prod_ext = {{34{prod_q[67]}}, prod_q};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vtx_q <= vtx_i;
      for (int j = 0; j < 3; j++) begin
        d1_q[j] <= sx33(vtx_i[2][j]) - sx33(vtx_i[1][j]);
        d2_q[j] <= sx33(vtx_i[1][j]) - sx33(vtx_i[0][j]);
        n_q[j]  <= '0;
      end
      dot_q <= '0;
    end else if (busy_q && (step_q != 5'd0) && (step_q <= StepAccEnd)) begin
      if (pstep < StepDot) begin
        if (pstep[0]) begin
          n_q[pstep[2:1]] <= n_q[pstep[2:1]] - $signed(prod_q[66:0]);
        end else begin
          n_q[pstep[2:1]] <= n_q[pstep[2:1]] + $signed(prod_q[66:0]);
        end
      end else if (pstep < StepExt) begin
        if (!prel_dot[0]) begin
          dot_q <= dot_q + $signed(prod_ext << 34);
        end else begin
          dot_q <= dot_q + $signed(prod_ext);
        end
      end else begin
        lp_q[prel_ext[1:0]] <= prod_q[47:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (finish) begin
      busy_q <= 1'b0;
    end else if (busy_q && (step_q != StepLast)) begin
      step_q <= step_q + 5'd1;
    end
  end

endmodule

[sv/svx_queue.sv]
// short queue of facing triangles between front and back
// depends on svx_pkg
`timescale 1ns / 1ps

module svx_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  svx_pkg::tri_t    push_data_i,
  input  logic             pop_i,
  output svx_pkg::tri_t    pop_data_o,
  output svx_pkg::q_stat_t q_stat_o
);
  import svx_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  tri_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[sv/svx_back.sv]
// back end: walks the 18 volume vertices of a queued triangle, one per beat,
// with saturated extrusion; depends on svx_pkg
`timescale 1ns / 1ps

module svx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  svx_pkg::q_stat_t q_stat_i,
  input  svx_pkg::tri_t    q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output svx_pkg::vec_t    out_vtx_o,
  output logic             out_last_o
);
  import svx_pkg::*;

  // position inside one edge quad: p, q, p', q, q', p'
  localparam logic [2:0] PosP     = 3'd0;
  localparam logic [2:0] PosQ     = 3'd1;
  localparam logic [2:0] PosPExt  = 3'd2;
  localparam logic [2:0] PosQ2    = 3'd3;
  localparam logic [2:0] PosQExt  = 3'd4;
  localparam logic [2:0] PosPExt2 = 3'd5;
  localparam logic [1:0] EdgeLast = 2'd2;

  logic        active_q;
  tri_t        cur_q;
  logic [1:0]  edge_q;
  logic [2:0]  pos_q;
  logic        out_valid_q;
  vec_t        out_vtx_q;
  logic        out_last_q;

  logic        load_out, emit, last_beat, use_q, use_ext;
  logic [1:0]  q_idx, v_idx;
  vec_t        base, vtx;
  logic signed [48:0] sum;

  assign load_out  = !out_valid_q || !out_stall_i;
  assign emit      = active_q && load_out;
  assign last_beat = (edge_q == EdgeLast) && (pos_q == PosPExt2);
  assign pop_o     = !q_stat_i.empty && (!active_q || (emit && last_beat));

  assign out_valid_o = out_valid_q;
  assign out_vtx_o   = out_vtx_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    case (pos_q)
      PosP:     begin use_q = 1'b0; use_ext = 1'b0; end
      PosQ:     begin use_q = 1'b1; use_ext = 1'b0; end
      PosPExt:  begin use_q = 1'b0; use_ext = 1'b1; end
      PosQ2:    begin use_q = 1'b1; use_ext = 1'b0; end
      PosQExt:  begin use_q = 1'b1; use_ext = 1'b1; end
      PosPExt2: begin use_q = 1'b0; use_ext = 1'b1; end
      default:  begin use_q = 1'b0; use_ext = 1'b0; end
    endcase
  end

  always_comb begin
    q_idx = (edge_q == EdgeLast) ? 2'd0 : edge_q + 2'd1;
    v_idx = use_q ? q_idx : edge_q;
    base  = cur_q.v[v_idx];
    sum   = '0;
    vtx   = base;
    for (int j = 0; j < 3; j++) begin
      sum = $signed({{17{base[j][31]}}, base[j]}) +
            $signed({cur_q.lp[j][47], cur_q.lp[j]});
      if (use_ext) begin
        // clamp to the signed 32-bit range
        if (sum[48:31] == {18{sum[48]}}) begin
          vtx[j] = sum[31:0];
        end else if (sum[48]) begin
          vtx[j] = 32'h8000_0000;
        end else begin
          vtx[j] = 32'h7FFF_FFFF;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      out_vtx_q  <= vtx;
      out_last_q <= last_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      edge_q      <= '0;
      pos_q       <= PosP;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= emit;
      end
      if (pop_o) begin
        active_q <= 1'b1;
        edge_q   <= '0;
        pos_q    <= PosP;
      end else if (emit && last_beat) begin
        active_q <= 1'b0;
      end else if (emit) begin
        if (pos_q == PosPExt2) begin
          pos_q  <= PosP;
          edge_q <= edge_q + 2'd1;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end

endmodule

[sv/svx_checker.sv]
// port-level checks for the shadow volume extruder, bound to the top level
// depends only on the top level's ports
`timescale 1ns / 1ps

module svx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [31:0] out_z_o,
  input logic        last_vertex_o
);

  // a stalled beat stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out beat dropped while stalled");

  // a stalled beat keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_x_o) && $stable(out_y_o) &&
      $stable(out_z_o) && $stable(last_vertex_o))
    else $error("out payload changed while stalled");

  // the front stalls its input once it has taken a triangle
  a_front_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("triangle taken while the previous one is in work");

  // no beat right after leaving reset
  a_reset_quiet : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("out beat offered straight out of reset");

endmodule

bind shadow_volume_triangle_extruder svx_checker u_svx_checker (.*);
